/* sv/rgbhsv_pkg.sv */
package rgbhsv_pkg;

   // Channel code width; the all-ones code means full intensity.
   localparam int CHANNEL_BITS = 12;
   // Saturation reaches exactly 1.0, which needs one more bit.
   localparam int SAT_BITS = CHANNEL_BITS + 1;
   // Six times the chroma needs three more bits than a channel.
   localparam int HUE_DIV_BITS = CHANNEL_BITS + 3;
   // One quotient bit per divider stage; the saturation quotient is the longest.
   localparam int DIV_STAGES = SAT_BITS;

   // Sector of the largest channel. Ties go to red first, then green.
   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   // One input item.
   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } pixel_type;

   // One result item.
   typedef struct packed {
      logic [CHANNEL_BITS-1:0] hue;
      logic [SAT_BITS-1:0]     saturation;
      logic [CHANNEL_BITS-1:0] value;
   } hsv_type;

   // After the sort stage: largest channel, chroma, sector and the signed channel difference.
   typedef struct packed {
      logic [CHANNEL_BITS-1:0] value;
      logic [CHANNEL_BITS-1:0] chroma;
      logic signed [CHANNEL_BITS:0] diff;
      sector_type              sector;
   } front_type;

   // Working set of the two dividers, carried down the pipeline.
   typedef struct packed {
      logic                    gray;
      logic [CHANNEL_BITS-1:0] sat_rem;
      logic [CHANNEL_BITS-1:0] sat_div;
      logic [SAT_BITS-1:0]     sat_quo;
      logic [HUE_DIV_BITS-1:0] hue_rem;
      logic [HUE_DIV_BITS-1:0] hue_div;
      logic [CHANNEL_BITS-1:0] hue_quo;
   } div_work_type;

endpackage

/* sv/rgbhsv_div_pipe.sv */
module rgbhsv_div_pipe (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  rgbhsv_pkg::div_work_type  in_work,
   output logic                      out_valid,
   input  logic                      out_ready,
   output rgbhsv_pkg::hsv_type       out_hsv
);

   localparam int CB  = rgbhsv_pkg::CHANNEL_BITS;
   localparam int HDB = rgbhsv_pkg::HUE_DIV_BITS;
   localparam int NS  = rgbhsv_pkg::DIV_STAGES;

   rgbhsv_pkg::div_work_type stage_ff [NS];
   rgbhsv_pkg::div_work_type stage_in [NS];
   rgbhsv_pkg::div_work_type src      [NS];
   logic [NS-1:0]            valid_ff;
   logic [NS-1:0]            src_valid;
   logic [NS-1:0]            stage_ready;

   assign in_ready = stage_ready[0];

   genvar i;
   generate
      for (i = 0; i < NS; i++) begin : g_stage
         logic [CB:0]  sat_trial;
         logic [CB:0]  sat_sub;
         logic         sat_bit;
         logic [HDB:0] hue_trial;
         logic [HDB:0] hue_sub;
         logic         hue_bit;

         // Source of this stage: the pipeline input or the stage before.
         if (i == 0) begin : g_first
            assign src[i]       = in_work;
            assign src_valid[i] = in_valid;
         end else begin : g_next
            assign src[i]       = stage_ff[i-1];
            assign src_valid[i] = valid_ff[i-1];
         end

         // A stage moves on when it is empty or its successor takes its item.
         if (i == NS - 1) begin : g_last_ready
            assign stage_ready[i] = !valid_ff[i] || out_ready;
         end else begin : g_mid_ready
            assign stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
         end

         // The first saturation step tests the whole-number bit, so it does not shift.
         if (i == 0) begin : g_sat_noshift
            assign sat_trial = {1'b0, src[i].sat_rem};
         end else begin : g_sat_shift
            assign sat_trial = {src[i].sat_rem, 1'b0};
         end
         assign sat_sub = sat_trial - {1'b0, src[i].sat_div};
         assign sat_bit = sat_trial >= {1'b0, src[i].sat_div};

         // Hue has one bit fewer, so it starts a stage later.
         assign hue_trial = {src[i].hue_rem, 1'b0};
         assign hue_sub   = hue_trial - {1'b0, src[i].hue_div};
         assign hue_bit   = (i > 0) && (hue_trial >= {1'b0, src[i].hue_div});

         // One restoring step of each divider.
         always_comb begin
            stage_in[i]         = src[i];
            stage_in[i].sat_rem = sat_bit ? sat_sub[CB-1:0] : sat_trial[CB-1:0];
            stage_in[i].sat_quo = {src[i].sat_quo[CB-1:0], sat_bit};
            if (i > 0) begin
               stage_in[i].hue_rem = hue_bit ? hue_sub[HDB-1:0] : hue_trial[HDB-1:0];
               stage_in[i].hue_quo = {src[i].hue_quo[CB-2:0], hue_bit};
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else if (stage_ready[i]) begin
               valid_ff[i] <= src_valid[i];
            end
            if (stage_ready[i] && src_valid[i]) begin
               stage_ff[i] <= stage_in[i];
            end
         end
      end
   endgenerate

   // A gray or black pixel has no hue and no saturation.
   assign out_valid          = valid_ff[NS-1];
   assign out_hsv.hue        = stage_ff[NS-1].gray ? '0 : stage_ff[NS-1].hue_quo;
   assign out_hsv.saturation = stage_ff[NS-1].gray ? '0 : stage_ff[NS-1].sat_quo;
   assign out_hsv.value      = stage_ff[NS-1].sat_div;

endmodule

/* sv/rgb_to_hsv_converter.sv */
// RGB to HSV converter, one pixel per item.
// An accepted item passes the sort stage, the hue numerator stage, then 13 divider
// stages that each resolve one quotient bit, before it reaches the result side.
// Throughput: one item per cycle; a stall on the result side only holds the stages
// that are full, so bubbles still close up.
// Reset clears every valid bit; the pipeline comes out of reset empty.
module rgb_to_hsv_converter (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rgbhsv_pkg::pixel_type   req_pixel,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rgbhsv_pkg::hsv_type     rsp_hsv
);

   localparam int CB  = rgbhsv_pkg::CHANNEL_BITS;
   localparam int HDB = rgbhsv_pkg::HUE_DIV_BITS;

   rgbhsv_pkg::front_type    front_ff;
   rgbhsv_pkg::front_type    front_in;
   logic                     front_valid_ff;
   rgbhsv_pkg::div_work_type work_ff;
   rgbhsv_pkg::div_work_type work_in;
   logic                     work_valid_ff;
   logic                     work_ready;
   logic                     div_ready;

   logic [CB-1:0]         min_chan;
   logic [HDB-1:0]        chroma_x;
   logic [HDB-1:0]        six_c;
   logic signed [HDB:0]   diff_x;
   logic signed [HDB:0]   offset;
   logic signed [HDB:0]   num_raw;
   logic signed [HDB:0]   num_wrap;

   assign req_ready  = !front_valid_ff || work_ready;
   assign work_ready = !work_valid_ff || div_ready;

   // Sort stage: pick the largest channel and its sector, the smallest, and the difference.
   always_comb begin
      front_in = '0;
      if (req_pixel.red >= req_pixel.green && req_pixel.red >= req_pixel.blue) begin
         front_in.value  = req_pixel.red;
         front_in.sector = rgbhsv_pkg::SECTOR_RED;
         front_in.diff   = $signed({1'b0, req_pixel.green}) - $signed({1'b0, req_pixel.blue});
      end else if (req_pixel.green >= req_pixel.blue) begin
         front_in.value  = req_pixel.green;
         front_in.sector = rgbhsv_pkg::SECTOR_GREEN;
         front_in.diff   = $signed({1'b0, req_pixel.blue}) - $signed({1'b0, req_pixel.red});
      end else begin
         front_in.value  = req_pixel.blue;
         front_in.sector = rgbhsv_pkg::SECTOR_BLUE;
         front_in.diff   = $signed({1'b0, req_pixel.red}) - $signed({1'b0, req_pixel.green});
      end
      min_chan = req_pixel.red;
      if (req_pixel.green < min_chan) begin
         min_chan = req_pixel.green;
      end
      if (req_pixel.blue < min_chan) begin
         min_chan = req_pixel.blue;
      end
      front_in.chroma = front_in.value - min_chan;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (req_ready) begin
         front_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         front_ff <= front_in;
      end
   end

   // Numerator stage: add the sector offset, wrap negatives by a full turn, form 6C.
   assign chroma_x = {{(HDB-CB){1'b0}}, front_ff.chroma};
   assign six_c    = (chroma_x << 2) + (chroma_x << 1);
   assign diff_x   = {{(HDB-CB){front_ff.diff[CB]}}, front_ff.diff};

   always_comb begin
      case (front_ff.sector)
         rgbhsv_pkg::SECTOR_RED:   offset = '0;
         rgbhsv_pkg::SECTOR_GREEN: offset = $signed({1'b0, chroma_x << 1});
         rgbhsv_pkg::SECTOR_BLUE:  offset = $signed({1'b0, chroma_x << 2});
         default:                  offset = '0;
      endcase
      num_raw  = diff_x + offset;
      num_wrap = num_raw[HDB] ? num_raw + $signed({1'b0, six_c}) : num_raw;

      work_in         = '0;
      work_in.gray    = (front_ff.chroma == '0);
      work_in.sat_rem = front_ff.chroma;
      work_in.sat_div = front_ff.value;
      work_in.hue_rem = num_wrap[HDB-1:0];
      work_in.hue_div = six_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
      end else if (work_ready) begin
         work_valid_ff <= front_valid_ff;
      end
      if (work_ready && front_valid_ff) begin
         work_ff <= work_in;
      end
   end

   // Saturation and hue quotients, one bit per stage.
   rgbhsv_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (work_valid_ff),
      .in_ready  (div_ready),
      .in_work   (work_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_hsv   (rsp_hsv)
   );

endmodule
